FILE: sv/cidr_pkg.sv
// ----------------------------------------------------------------------------
// cidr_pkg
// Shared types, constants and mask helpers for the CIDR allow/deny filter.
// ----------------------------------------------------------------------------
`default_nettype none

package cidr_pkg;

  // Entries per rule table
  localparam int RULES_PER_TABLE = 16;
  localparam int IDX_W     = (RULES_PER_TABLE > 1) ? $clog2(RULES_PER_TABLE) : 1;
  // Rule memory holds four tables: {family, list, index}
  localparam int RAM_AW    = IDX_W + 2;
  localparam int RAM_DEPTH = 2 ** RAM_AW;

  localparam int ADDR_W = 128;

  // Item modes
  localparam logic [1:0] MODE_WRITE    = 2'd0;
  localparam logic [1:0] MODE_QUERY_V4 = 2'd1;
  localparam logic [1:0] MODE_QUERY_V6 = 2'd2;

  // Prefix length limits per family
  localparam logic [7:0] V4_MAX_PLEN = 8'd32;
  localparam logic [7:0] V6_MAX_PLEN = 8'd128;

  // Status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_TOO_LONG = 1'b1;

  // Configuration register indexes
  localparam logic CFG_DEFAULT_ALLOW  = 1'b0;
  localparam logic CFG_POLICY_ENABLED = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic        rule_list;
    logic        rule_family;
    logic [3:0]  rule_slot;
    logic        rule_enable;
    logic [7:0]  prefix_len;
    logic [63:0] address_high;
    logic [63:0] address_low;
  } in_word_t;

  typedef struct packed {
    logic allowed;
    logic status;
  } out_word_t;

  // One stored rule; IPv4 rules keep their network in bits 31..0
  typedef struct packed {
    logic              valid;
    logic [7:0]        plen;
    logic [ADDR_W-1:0] net;
  } rule_entry_t;

  localparam int ENTRY_W = $bits(rule_entry_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_FINISH
  } state_t;

  // Prefix mask; plen is at most 32 for IPv4 and 128 for IPv6
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic is_v6,
                                                    input logic [7:0] plen);
    logic [31:0]       m4;
    logic [ADDR_W-1:0] m6;
    m4 = ~(32'hFFFF_FFFF >> plen);
    m6 = ~({ADDR_W{1'b1}} >> plen);
    return is_v6 ? m6 : {{(ADDR_W-32){1'b0}}, m4};
  endfunction

  // Address as compared against a table: IPv4 keeps only bits 31..0
  function automatic logic [ADDR_W-1:0] family_addr(input logic is_v6,
                                                    input logic [63:0] hi,
                                                    input logic [63:0] lo);
    return is_v6 ? {hi, lo} : {{(ADDR_W-32){1'b0}}, lo[31:0]};
  endfunction

endpackage

`default_nettype wire

FILE: sv/cidr_ram.sv
// ----------------------------------------------------------------------------
// cidr_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cidr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/cidr_allow_deny_filter_unit.sv
// ----------------------------------------------------------------------------
// cidr_allow_deny_filter_unit
// IP CIDR access-control list with IPv4/IPv6 deny and allow rule tables.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data) carries rule writes and address
//   queries; out channel (out_valid/out_ready/out_data) returns one word per
//   input word; cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) sets
//   default_allow and policy_enabled and is always ready.
//   All four tables live in one rule memory addressed {family, list, slot}.
//   A write or an unused mode goes from idle straight to the finish state,
//   which loads the output register as soon as it is free.
//   A query reads the deny table and then the allow table of its family, one
//   entry per cycle through the single memory read port, in the scan state;
//   the last state compares the final entry and the finish state then loads
//   the output register as soon as it is free.
//   One word is processed at a time; a new word is taken as soon as the
//   previous one has moved into the output register, even if that register
//   is still waiting on out_ready. A stalled receiver holds out_data and,
//   once the next word is done, holds that word in the finish state.
//   Reset sets default_allow to 1 and policy_enabled to 0, then clears every
//   entry of the rule memory (RAM_DEPTH, 64 at 16 rules) one entry per cycle
//   with in_ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module cidr_allow_deny_filter_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire cidr_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output cidr_pkg::out_word_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic                cfg_data
);

  import cidr_pkg::*;

  state_t state, state_next;

  logic              default_allow;
  logic              policy_enabled;

  logic [RAM_AW-1:0] clr_idx;
  logic [IDX_W-1:0]  scan_idx;
  logic              scan_list;
  logic              rd_vld;
  logic              rd_list;

  logic              q_v6;
  logic              q_query;
  logic              wr_status;
  logic [ADDR_W-1:0] q_addr;
  logic              deny_hit;
  logic              allow_hit;

  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  rule_entry_t       ram_wdata;
  logic [RAM_AW-1:0] ram_raddr;
  rule_entry_t       ram_rdata;

  logic              accept;
  logic              in_query;
  logic              in_too_long;
  logic              in_slot_ok;
  logic              out_free;
  logic              entry_hit;
  logic [ADDR_W-1:0] in_addr;
  logic [7:0]        in_limit;
  out_word_t         result;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Decode the incoming word
  assign in_query    = (in_data.mode == MODE_QUERY_V4) || (in_data.mode == MODE_QUERY_V6);
  assign in_limit    = in_data.rule_family ? V6_MAX_PLEN : V4_MAX_PLEN;
  assign in_too_long = in_data.rule_enable && (in_data.prefix_len > in_limit);
  assign in_slot_ok  = 32'(in_data.rule_slot) < RULES_PER_TABLE;
  assign in_addr     = family_addr(in_data.rule_family, in_data.address_high,
                                   in_data.address_low);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      default_allow  <= 1'b1;
      policy_enabled <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEFAULT_ALLOW:  default_allow  <= cfg_data;
        CFG_POLICY_ENABLED: policy_enabled <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == {RAM_AW{1'b1}}) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = in_query ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        if (scan_list && scan_idx == IDX_W'(RULES_PER_TABLE - 1)) state_next = ST_LAST;
      end
      ST_LAST: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // State outputs: handshake and memory write port
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_idx;
    ram_wdata = '0;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        ram_waddr = {in_data.rule_family, in_data.rule_list, IDX_W'(in_data.rule_slot)};
        ram_we    = in_valid && (in_data.mode == MODE_WRITE) && in_slot_ok && !in_too_long;
        if (in_data.rule_enable) begin
          ram_wdata.valid = 1'b1;
          ram_wdata.plen  = in_data.prefix_len;
          ram_wdata.net   = in_addr & prefix_mask(in_data.rule_family, in_data.prefix_len);
        end
      end
      ST_SCAN, ST_LAST, ST_FINISH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == ST_CLEAR) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // Advance the scan: deny table first, then allow table
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx  <= '0;
      scan_list <= 1'b0;
      rd_vld    <= 1'b0;
      rd_list   <= 1'b0;
    end else begin
      rd_vld  <= (state == ST_SCAN);
      rd_list <= scan_list;
      if (accept) begin
        scan_idx  <= '0;
        scan_list <= 1'b0;
      end else if (state == ST_SCAN) begin
        if (scan_idx == IDX_W'(RULES_PER_TABLE - 1)) begin
          scan_idx  <= '0;
          scan_list <= 1'b1;
        end else begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
    end
  end

  // Writes happen only in the clear and idle states and read data is used only
  // from scan reads, so the state machine itself keeps the two ports off the same entry at once
  assign ram_raddr = {q_v6, scan_list, scan_idx};

  cidr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_rules (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Compare the returned entry with the query address
  assign entry_hit = ram_rdata.valid &&
                     ((q_addr & prefix_mask(q_v6, ram_rdata.plen)) == ram_rdata.net);

  // Hold the word under work and accumulate hits
  always_ff @(posedge clk) begin
    if (accept) begin
      q_v6      <= (in_data.mode == MODE_QUERY_V6);
      q_query   <= in_query;
      q_addr    <= family_addr(in_data.mode == MODE_QUERY_V6, in_data.address_high,
                               in_data.address_low);
      wr_status <= ((in_data.mode == MODE_WRITE) && in_slot_ok && in_too_long)
                   ? STATUS_TOO_LONG : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || accept) begin
      deny_hit  <= 1'b0;
      allow_hit <= 1'b0;
    end else if (rd_vld && entry_hit) begin
      if (rd_list) allow_hit <= 1'b1;
      else         deny_hit  <= 1'b1;
    end
  end

  // Verdict
  always_comb begin
    result.allowed = 1'b0;
    result.status  = STATUS_OK;
    if (q_query) begin
      result.allowed = policy_enabled && !deny_hit && (allow_hit || default_allow);
    end else begin
      result.status = wr_status;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      out_data <= result;
    end
  end

  // Checks
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_LAST) |-> !ram_we)
    else $error("rule memory written during a scan");

  a_read_follows_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(state) == ST_SCAN)
    else $error("compare without a scan read");

  a_load_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("output loaded outside finish");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE && state != ST_CLEAR)
    else $error("accepted word not processed");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CIDR allow/deny filter: drives rule writes and
// IPv4/IPv6 queries with bursty traffic and a stalling receiver, predicts
// every verdict and status word and compares them in order of arrival.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cidr_pkg::*;

  localparam logic       LIST_DENY   = 1'b0;
  localparam logic       LIST_ALLOW  = 1'b1;
  localparam logic       FAM_V4      = 1'b0;
  localparam logic       FAM_V6      = 1'b1;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         PHASES      = 7;
  localparam int         PHASE_ITEMS = 100;
  localparam int         LONG_HOLD   = 400;

  // Rule tables and verdicts that the block is expected to produce
  class verdict_book;
    out_word_t    verdicts_due[$];
    int           failures;
    int           checked;
    logic         dflt_allow;
    logic         enabled;
    bit           v4_on [2][RULES_PER_TABLE];
    logic [7:0]   v4_len[2][RULES_PER_TABLE];
    logic [31:0]  v4_net[2][RULES_PER_TABLE];
    bit           v6_on [2][RULES_PER_TABLE];
    logic [7:0]   v6_len[2][RULES_PER_TABLE];
    logic [127:0] v6_net[2][RULES_PER_TABLE];

    function new();
      failures   = 0;
      checked    = 0;
      dflt_allow = 1'b1;
      enabled    = 1'b0;
      for (int l = 0; l < 2; l++) begin
        for (int i = 0; i < RULES_PER_TABLE; i++) begin
          v4_on[l][i]  = 1'b0;
          v4_len[l][i] = '0;
          v4_net[l][i] = '0;
          v6_on[l][i]  = 1'b0;
          v6_len[l][i] = '0;
          v6_net[l][i] = '0;
        end
      end
    endfunction

    function void set_reg(logic idx, logic val);
      if (idx == CFG_DEFAULT_ALLOW) dflt_allow = val;
      else enabled = val;
    endfunction

    function logic [31:0] v4_mask(logic [7:0] n);
      int sh;
      if (n == 8'd0) return '0;
      sh = 32 - int'(n);
      return 32'hFFFF_FFFF << sh;
    endfunction

    function logic [127:0] v6_mask(logic [7:0] n);
      int sh;
      if (n == 8'd0) return '0;
      sh = 128 - int'(n);
      return {128{1'b1}} << sh;
    endfunction

    function bit v4_hit(int lst, logic [31:0] a);
      for (int i = 0; i < RULES_PER_TABLE; i++)
        if (v4_on[lst][i] && ((a & v4_mask(v4_len[lst][i])) == v4_net[lst][i])) return 1'b1;
      return 1'b0;
    endfunction

    function bit v6_hit(int lst, logic [127:0] a);
      for (int i = 0; i < RULES_PER_TABLE; i++)
        if (v6_on[lst][i] && ((a & v6_mask(v6_len[lst][i])) == v6_net[lst][i])) return 1'b1;
      return 1'b0;
    endfunction

    // Apply one accepted word to the tables and queue its verdict
    function void take_item(in_word_t w);
      out_word_t    r;
      int           s;
      int           l;
      logic [31:0]  a4;
      logic [127:0] a6;
      r.allowed = 1'b0;
      r.status  = STATUS_OK;
      s  = int'(w.rule_slot);
      l  = int'(w.rule_list);
      a4 = w.address_low[31:0];
      a6 = {w.address_high, w.address_low};
      case (w.mode)
        MODE_WRITE: begin
          if (s < RULES_PER_TABLE) begin
            if (w.rule_family == FAM_V4) begin
              if (!w.rule_enable) begin
                v4_on[l][s]  = 1'b0;
                v4_len[l][s] = '0;
                v4_net[l][s] = '0;
              end else if (w.prefix_len > V4_MAX_PLEN) begin
                r.status = STATUS_TOO_LONG;
              end else begin
                v4_on[l][s]  = 1'b1;
                v4_len[l][s] = w.prefix_len;
                v4_net[l][s] = a4 & v4_mask(w.prefix_len);
              end
            end else begin
              if (!w.rule_enable) begin
                v6_on[l][s]  = 1'b0;
                v6_len[l][s] = '0;
                v6_net[l][s] = '0;
              end else if (w.prefix_len > V6_MAX_PLEN) begin
                r.status = STATUS_TOO_LONG;
              end else begin
                v6_on[l][s]  = 1'b1;
                v6_len[l][s] = w.prefix_len;
                v6_net[l][s] = a6 & v6_mask(w.prefix_len);
              end
            end
          end
        end
        MODE_QUERY_V4: begin
          if (enabled) begin
            if (v4_hit(int'(LIST_DENY), a4)) r.allowed = 1'b0;
            else if (v4_hit(int'(LIST_ALLOW), a4)) r.allowed = 1'b1;
            else r.allowed = dflt_allow;
          end
        end
        MODE_QUERY_V6: begin
          if (enabled) begin
            if (v6_hit(int'(LIST_DENY), a6)) r.allowed = 1'b0;
            else if (v6_hit(int'(LIST_ALLOW), a6)) r.allowed = 1'b1;
            else r.allowed = dflt_allow;
          end
        end
        default: ;
      endcase
      verdicts_due.insert(verdicts_due.size(), r);
    endfunction

    function void report(string what, logic want, logic got);
      failures++;
      if (failures <= 10)
        $display("result %0d: %s expected %0b got %0b", checked, what, want, got);
    endfunction

    // Compare one output word with the oldest expected verdict
    function void check_verdict(out_word_t got);
      out_word_t want;
      if (verdicts_due.size() == 0) begin
        failures++;
        if (failures <= 10) $display("output word %b with nothing expected", got);
        return;
      end
      want = verdicts_due.pop_front();
      if (got.allowed !== want.allowed) report("allowed", want.allowed, got.allowed);
      if (got.status !== want.status) report("status", want.status, got.status);
      checked++;
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_index = 1'b0;
  logic      cfg_data = 1'b0;

  int          hold_asks = 0;
  logic [31:0]  v4_pool[$];
  logic [127:0] v6_pool[$];

  verdict_book book = new();

  cidr_allow_deny_filter_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Receiver: take output words on a changing stall pattern, with long holds on request
  initial begin : receive_side
    int style;
    int span;
    int hold_left;
    int hold_seen;
    style     = 0;
    span      = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) book.check_verdict(out_data);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (span == 0) begin
          style = $urandom_range(0, 3);
          span  = $urandom_range(16, 120);
        end
        span--;
        case (style)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 4) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic in_word_t make_word(logic [1:0] m, logic lst, logic fam, logic [3:0] slot,
                                         logic en, logic [7:0] plen, logic [63:0] hi,
                                         logic [63:0] lo);
    in_word_t w;
    w.mode         = m;
    w.rule_list    = lst;
    w.rule_family  = fam;
    w.rule_slot    = slot;
    w.rule_enable  = en;
    w.prefix_len   = plen;
    w.address_high = hi;
    w.address_low  = lo;
    return w;
  endfunction

  // Build one random word; queries mostly reuse stored networks so rules get hit
  function automatic in_word_t random_word();
    in_word_t     w;
    int           pick;
    int           r;
    logic [127:0] a;
    w.mode         = 2'($urandom_range(0, 3));
    w.rule_list    = 1'($urandom_range(0, 1));
    w.rule_family  = 1'($urandom_range(0, 1));
    w.rule_slot    = 4'($urandom_range(0, 15));
    w.rule_enable  = ($urandom_range(0, 4) != 0);
    w.prefix_len   = 8'($urandom_range(0, 255));
    w.address_high = {$urandom, $urandom};
    w.address_low  = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    r    = $urandom_range(0, 39);
    if (pick < 36) begin
      w.mode = MODE_WRITE;
      if (w.rule_family == FAM_V4) begin
        if (r == 0) w.prefix_len = 8'd0;
        else if (r > 3) w.prefix_len = 8'($urandom_range(8, 32));
        v4_pool.insert(v4_pool.size(), w.address_low[31:0]);
        if (v4_pool.size() > 32) void'(v4_pool.pop_front());
      end else begin
        if (r == 0) w.prefix_len = 8'd0;
        else if (r > 3) w.prefix_len = 8'($urandom_range(16, 128));
        v6_pool.insert(v6_pool.size(), {w.address_high, w.address_low});
        if (v6_pool.size() > 32) void'(v6_pool.pop_front());
      end
    end else if (pick < 66) begin
      w.mode = MODE_QUERY_V4;
      if (v4_pool.size() > 0 && $urandom_range(0, 9) < 7) begin
        a = {96'd0, v4_pool[$urandom_range(0, v4_pool.size() - 1)]};
        if ($urandom_range(0, 1)) a[$urandom_range(0, 31)] ^= 1'b1;
        w.address_low[31:0] = a[31:0];
      end
    end else if (pick < 95) begin
      w.mode = MODE_QUERY_V6;
      if (v6_pool.size() > 0 && $urandom_range(0, 9) < 7) begin
        a = v6_pool[$urandom_range(0, v6_pool.size() - 1)];
        if ($urandom_range(0, 1)) a[$urandom_range(0, 127)] ^= 1'b1;
        {w.address_high, w.address_low} = a;
      end
    end else begin
      w.mode = MODE_UNUSED;
    end
    return w;
  endfunction

  // Offer one word and hold it until accepted; valid stays high for the caller
  task automatic send_word(input in_word_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.take_item(w);
  endtask

  // Drop valid and wait until every expected word has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (book.pending() > 0) @(posedge clk);
  endtask

  // Write both registers back to back; only called while the block is idle
  task automatic set_policy(input logic dflt, input logic en);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_DEFAULT_ALLOW;
    cfg_data  <= dflt;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.set_reg(CFG_DEFAULT_ALLOW, dflt);
    cfg_index <= CFG_POLICY_ENABLED;
    cfg_data  <= en;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.set_reg(CFG_POLICY_ENABLED, en);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic dflt_seq[PHASES];
    logic en_seq[PHASES];
    int   left;
    int   burst;
    int   gap;
    dflt_seq = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    en_seq   = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Query before the policy is enabled: refused
    send_word(make_word(MODE_QUERY_V4, LIST_ALLOW, FAM_V6, 4'd15, 1'b1, 8'd255,
                        '1, 64'h0));
    drain();
    set_policy(1'b1, 1'b1);

    // IPv4 deny/allow, too-long prefixes and clearing
    send_word(make_word(MODE_WRITE, LIST_DENY, FAM_V4, 4'd0, 1'b1, 8'd24,
                        '1, 64'hDEAD_BEEF_0A01_02FF));
    send_word(make_word(MODE_QUERY_V4, LIST_DENY, FAM_V4, 4'd0, 1'b0, 8'd0,
                        '1, 64'hFFFF_FFFF_0A01_0207));
    send_word(make_word(MODE_QUERY_V4, LIST_DENY, FAM_V4, 4'd0, 1'b0, 8'd0,
                        64'h0, 64'h0000_0000_0A01_0307));
    send_word(make_word(MODE_WRITE, LIST_ALLOW, FAM_V4, 4'd15, 1'b1, 8'd32,
                        64'h0, 64'h0000_0000_0A01_0307));
    send_word(make_word(MODE_WRITE, LIST_DENY, FAM_V4, 4'd1, 1'b1, 8'd33,
                        64'h0, 64'h0000_0000_0A01_0307));
    send_word(make_word(MODE_WRITE, LIST_DENY, FAM_V4, 4'd2, 1'b1, 8'd255,
                        64'h0, 64'h0000_0000_0A01_0307));
    send_word(make_word(MODE_QUERY_V4, LIST_DENY, FAM_V4, 4'd0, 1'b0, 8'd0,
                        64'h0, 64'h0000_0000_0A01_0307));
    send_word(make_word(MODE_WRITE, LIST_DENY, FAM_V4, 4'd0, 1'b0, 8'd200,
                        '1, '1));
    send_word(make_word(MODE_QUERY_V4, LIST_DENY, FAM_V4, 4'd0, 1'b0, 8'd0,
                        64'h0, 64'h0000_0000_0A01_0207));
    // IPv6 full, zero, too-long and half-width prefixes, unused mode, IPv4 zero prefix, clearing
    send_word(make_word(MODE_WRITE, LIST_DENY, FAM_V6, 4'd3, 1'b1, 8'd128, '1, '1));
    send_word(make_word(MODE_QUERY_V6, LIST_DENY, FAM_V4, 4'd0, 1'b0, 8'd0, '1, '1));
    send_word(make_word(MODE_WRITE, LIST_ALLOW, FAM_V6, 4'd0, 1'b1, 8'd0, '1, '1));
    send_word(make_word(MODE_QUERY_V6, LIST_ALLOW, FAM_V6, 4'd0, 1'b1, 8'd0,
                        64'h0, 64'h0));
    send_word(make_word(MODE_WRITE, LIST_DENY, FAM_V6, 4'd4, 1'b1, 8'd129, '1, '1));
    send_word(make_word(MODE_WRITE, LIST_ALLOW, FAM_V6, 4'd1, 1'b1, 8'd64,
                        64'h0123_4567_89AB_CDEF, '1));
    send_word(make_word(MODE_UNUSED, 1'b1, 1'b1, 4'd15, 1'b1, 8'd255, '1, '1));
    send_word(make_word(MODE_WRITE, LIST_ALLOW, FAM_V4, 4'd1, 1'b1, 8'd0,
                        64'h0, 64'h0000_0000_FFFF_FFFF));
    send_word(make_word(MODE_QUERY_V4, LIST_ALLOW, FAM_V6, 4'd15, 1'b1, 8'd255, '1, '1));
    send_word(make_word(MODE_WRITE, LIST_ALLOW, FAM_V6, 4'd0, 1'b0, 8'd0, 64'h0, 64'h0));
    send_word(make_word(MODE_WRITE, LIST_ALLOW, FAM_V4, 4'd1, 1'b0, 8'd255, '1, '1));
    send_word(make_word(MODE_QUERY_V6, LIST_DENY, FAM_V4, 4'd0, 1'b0, 8'd0,
                        64'h0123_4567_89AB_CDEF, 64'h5555_AAAA_0F0F_F0F0));
    drain();

    // Random traffic in bursts, one register setting per phase
    for (int ph = 0; ph < PHASES; ph++) begin
      set_policy(dflt_seq[ph], en_seq[ph]);
      left = PHASE_ITEMS;
      while (left > 0) begin
        if ($urandom_range(0, 7) == 0) burst = $urandom_range(20, 40);
        else burst = $urandom_range(1, 12);
        for (int i = 0; i < burst && left > 0; i++) begin
          send_word(random_word());
          left--;
          // Stall the receiver for a long stretch while words keep coming
          if ((ph == 1 || ph == 4) && left == PHASE_ITEMS / 2) hold_asks <= hold_asks + 1;
        end
        if ($urandom_range(0, 3) == 0) gap = 0;
        else gap = $urandom_range(1, 40);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        if ($urandom_range(0, 49) == 0) drain();
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (book.failures == 0 && book.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
